FILE: rtl/fmc_pkg.sv
// ----------------------------------------------------------------------------
// fmc_pkg
// Widths, signature constants and format codes shared by the file magic
// classifier.
// ----------------------------------------------------------------------------
package fmc_pkg;

   localparam int WORD_W  = 64;
   localparam int COUNT_W = 5;
   localparam int CODE_W  = 6;

   // Stream payload widths, padded to whole bytes
   localparam int REQ_DATA_W = 136;
   localparam int RSP_DATA_W = 8;

   typedef logic [WORD_W-1:0]  word_type;
   typedef logic [COUNT_W-1:0] count_type;
   typedef logic [CODE_W-1:0]  code_type;

   // Long signatures
   localparam logic [63:0] SIG_APETAG   = 64'h4150455441474558;
   localparam logic [63:0] SIG_AR       = 64'h213C617263683E0A;
   localparam logic [63:0] SIG_ASF_A    = 64'h3026B2758E66CF11;
   localparam logic [63:0] SIG_ASF_B    = 64'hA6D900AA0062CE6C;
   localparam logic [63:0] SIG_PNG      = 64'h89504E470D0A1A0A;
   localparam logic [63:0] SIG_YUV4MPEG = 64'h595556344D504547;
   localparam logic [63:0] SIG_RIFF_AVI = 64'h415649204C495354;
   localparam logic [55:0] SIG_RAR      = 56'h526172211A0700;
   localparam logic [39:0] SIG_AIFF     = 40'h464F524D00;
   localparam logic [31:0] SIG_MP4      = 32'h66747970;
   localparam logic [31:0] SIG_MOOV     = 32'h6D6F6F76;
   localparam logic [31:0] SIG_RIFF     = 32'h52494646;
   localparam logic [31:0] SIG_WAVE     = 32'h57415645;
   localparam logic [7:0]  YUV_BYTE8    = 8'h32;
   localparam logic [7:0]  YUV_BYTE9    = 8'h20;
   localparam logic [15:0] ADTS_MASK    = 16'hFFF6;
   localparam logic [15:0] ADTS_SYNC    = 16'hFFF0;
   localparam logic [10:0] MPA_SYNC     = 11'h7FF;

   // Valid byte thresholds
   localparam count_type CNT_MIN   = 5'd2;
   localparam count_type CNT_WORD4 = 5'd4;
   localparam count_type CNT_WORD8 = 5'd8;
   localparam count_type CNT_YUV   = 5'd10;
   localparam count_type CNT_WAVE  = 5'd12;
   localparam count_type CNT_FULL  = 5'd16;

   // Format codes
   localparam code_type FMT_UNKNOWN  = 6'd0;
   localparam code_type FMT_APETAG   = 6'd1;
   localparam code_type FMT_AR       = 6'd2;
   localparam code_type FMT_ASF      = 6'd3;
   localparam code_type FMT_PNG      = 6'd4;
   localparam code_type FMT_YUV4MPEG = 6'd5;
   localparam code_type FMT_MP4      = 6'd6;
   localparam code_type FMT_QT       = 6'd7;
   localparam code_type FMT_RAR      = 6'd8;
   localparam code_type FMT_GIF87A   = 6'd9;
   localparam code_type FMT_GIF89A   = 6'd10;
   localparam code_type FMT_7Z       = 6'd11;
   localparam code_type FMT_XZ       = 6'd12;
   localparam code_type FMT_AIFF     = 6'd13;
   localparam code_type FMT_DIRAC    = 6'd14;
   localparam code_type FMT_ELF      = 6'd15;
   localparam code_type FMT_FLAC     = 6'd16;
   localparam code_type FMT_IVF      = 6'd17;
   localparam code_type FMT_JAVA     = 6'd18;
   localparam code_type FMT_EBML     = 6'd19;
   localparam code_type FMT_MIDI     = 6'd20;
   localparam code_type FMT_MONKEY   = 6'd21;
   localparam code_type FMT_OGG      = 6'd22;
   localparam code_type FMT_PSD      = 6'd23;
   localparam code_type FMT_AVI      = 6'd24;
   localparam code_type FMT_WAVE     = 6'd25;
   localparam code_type FMT_RIFF     = 6'd26;
   localparam code_type FMT_TIFF_BE  = 6'd27;
   localparam code_type FMT_TIFF_LE  = 6'd28;
   localparam code_type FMT_UTF32    = 6'd29;
   localparam code_type FMT_WAVPACK  = 6'd30;
   localparam code_type FMT_ICO      = 6'd31;
   localparam code_type FMT_LZIP     = 6'd32;
   localparam code_type FMT_ZIP      = 6'd33;
   localparam code_type FMT_ZSTD     = 6'd34;
   localparam code_type FMT_BZIP2    = 6'd35;
   localparam code_type FMT_FLV      = 6'd36;
   localparam code_type FMT_GZIP     = 6'd37;
   localparam code_type FMT_ID3V2    = 6'd38;
   localparam code_type FMT_UTF8     = 6'd39;
   localparam code_type FMT_AC3      = 6'd40;
   localparam code_type FMT_JPEG     = 6'd41;
   localparam code_type FMT_LHA      = 6'd42;
   localparam code_type FMT_LZW      = 6'd43;
   localparam code_type FMT_PE       = 6'd44;
   localparam code_type FMT_UTF16    = 6'd45;
   localparam code_type FMT_BMP      = 6'd46;
   localparam code_type FMT_ADTS     = 6'd47;
   localparam code_type FMT_MPA      = 6'd48;
   localparam code_type FMT_LAST     = FMT_MPA;

endpackage

FILE: rtl/fmc_classify.sv
// ----------------------------------------------------------------------------
// fmc_classify
// Signature compare bank and priority select for one file header.
// ----------------------------------------------------------------------------
module fmc_classify (
   input  fmc_pkg::word_type  head_word,
   input  fmc_pkg::word_type  tail_word,
   input  fmc_pkg::count_type byte_count,
   output fmc_pkg::code_type  format_code
);

   fmc_pkg::word_type sig;
   fmc_pkg::code_type code64;
   fmc_pkg::code_type code48;
   fmc_pkg::code_type code32;
   fmc_pkg::code_type code24;
   fmc_pkg::code_type code16;
   fmc_pkg::code_type riff_code;
   logic              yuv_hit;

   // Bytes beyond the count are zeroed; counts above sixteen behave as
   // sixteen since only >= thresholds are used
   always_comb begin
      if (byte_count >= fmc_pkg::CNT_WORD8) begin
         sig = head_word;
      end else if (byte_count >= fmc_pkg::CNT_WORD4) begin
         sig = {head_word[63:32], 32'h0};
      end else begin
         sig = {head_word[63:48], 48'h0};
      end
   end

   always_comb begin
      case (sig)
         fmc_pkg::SIG_APETAG: code64 = fmc_pkg::FMT_APETAG;
         fmc_pkg::SIG_AR:     code64 = fmc_pkg::FMT_AR;
         fmc_pkg::SIG_ASF_A:  code64 = fmc_pkg::FMT_ASF;
         fmc_pkg::SIG_ASF_B:  code64 = fmc_pkg::FMT_ASF;
         fmc_pkg::SIG_PNG:    code64 = fmc_pkg::FMT_PNG;
         default:             code64 = fmc_pkg::FMT_UNKNOWN;
      endcase
   end

   always_comb begin
      case (sig[63:16])
         48'h474946383761: code48 = fmc_pkg::FMT_GIF87A;
         48'h474946383961: code48 = fmc_pkg::FMT_GIF89A;
         48'h377ABCAF271C: code48 = fmc_pkg::FMT_7Z;
         48'hFD377A585A00: code48 = fmc_pkg::FMT_XZ;
         default:          code48 = fmc_pkg::FMT_UNKNOWN;
      endcase
   end

   always_comb begin
      case (sig[63:32])
         32'h42424344: code32 = fmc_pkg::FMT_DIRAC;
         32'h7F454C46: code32 = fmc_pkg::FMT_ELF;
         32'h664C6143: code32 = fmc_pkg::FMT_FLAC;
         32'h444B4946: code32 = fmc_pkg::FMT_IVF;
         32'hCAFEBABE: code32 = fmc_pkg::FMT_JAVA;
         32'h1A45DFA3: code32 = fmc_pkg::FMT_EBML;
         32'h4D546864: code32 = fmc_pkg::FMT_MIDI;
         32'h4D414320: code32 = fmc_pkg::FMT_MONKEY;
         32'h4F676753: code32 = fmc_pkg::FMT_OGG;
         32'h38425053: code32 = fmc_pkg::FMT_PSD;
         32'h4D4D002A: code32 = fmc_pkg::FMT_TIFF_BE;
         32'h49492A00: code32 = fmc_pkg::FMT_TIFF_LE;
         32'hFFFE0000: code32 = fmc_pkg::FMT_UTF32;
         32'h7776706B: code32 = fmc_pkg::FMT_WAVPACK;
         32'h00000100: code32 = fmc_pkg::FMT_ICO;
         32'h4C5A4950: code32 = fmc_pkg::FMT_LZIP;
         32'h504B0304: code32 = fmc_pkg::FMT_ZIP;
         32'h504B0506: code32 = fmc_pkg::FMT_ZIP;
         32'h504B0708: code32 = fmc_pkg::FMT_ZIP;
         32'h28B52FFD: code32 = fmc_pkg::FMT_ZSTD;
         default:      code32 = fmc_pkg::FMT_UNKNOWN;
      endcase
   end

   always_comb begin
      case (sig[63:40])
         24'h425A68: code24 = fmc_pkg::FMT_BZIP2;
         24'h464C56: code24 = fmc_pkg::FMT_FLV;
         24'h1F8B08: code24 = fmc_pkg::FMT_GZIP;
         24'h494433: code24 = fmc_pkg::FMT_ID3V2;
         24'hEFBBBF: code24 = fmc_pkg::FMT_UTF8;
         default:    code24 = fmc_pkg::FMT_UNKNOWN;
      endcase
   end

   always_comb begin
      case (sig[63:48])
         16'h0B77: code16 = fmc_pkg::FMT_AC3;
         16'hFFD8: code16 = fmc_pkg::FMT_JPEG;
         16'h1FA0: code16 = fmc_pkg::FMT_LHA;
         16'h1F9D: code16 = fmc_pkg::FMT_LZW;
         16'h4D5A: code16 = fmc_pkg::FMT_PE;
         16'hFFFE: code16 = fmc_pkg::FMT_UTF16;
         16'h424D: code16 = fmc_pkg::FMT_BMP;
         default:  code16 = fmc_pkg::FMT_UNKNOWN;
      endcase
   end

   assign yuv_hit = (sig == fmc_pkg::SIG_YUV4MPEG) && (byte_count >= fmc_pkg::CNT_YUV)
                    && (tail_word[63:56] == fmc_pkg::YUV_BYTE8)
                    && (tail_word[55:48] == fmc_pkg::YUV_BYTE9);

   always_comb begin
      if ((byte_count >= fmc_pkg::CNT_FULL) && (tail_word == fmc_pkg::SIG_RIFF_AVI)) begin
         riff_code = fmc_pkg::FMT_AVI;
      end else if ((byte_count >= fmc_pkg::CNT_WAVE)
                   && (tail_word[63:32] == fmc_pkg::SIG_WAVE)) begin
         riff_code = fmc_pkg::FMT_WAVE;
      end else begin
         riff_code = fmc_pkg::FMT_RIFF;
      end
   end

   always_comb begin
      if (byte_count < fmc_pkg::CNT_MIN) begin
         format_code = fmc_pkg::FMT_UNKNOWN;
      end else if (code64 != fmc_pkg::FMT_UNKNOWN) begin
         format_code = code64;
      end else if (yuv_hit) begin
         format_code = fmc_pkg::FMT_YUV4MPEG;
      end else if (sig[31:0] == fmc_pkg::SIG_MP4) begin
         format_code = fmc_pkg::FMT_MP4;
      end else if (sig[31:0] == fmc_pkg::SIG_MOOV) begin
         format_code = fmc_pkg::FMT_QT;
      end else if (sig[63:8] == fmc_pkg::SIG_RAR) begin
         format_code = fmc_pkg::FMT_RAR;
      end else if (code48 != fmc_pkg::FMT_UNKNOWN) begin
         format_code = code48;
      end else if (sig[63:24] == fmc_pkg::SIG_AIFF) begin
         format_code = fmc_pkg::FMT_AIFF;
      end else if (sig[63:32] == fmc_pkg::SIG_RIFF) begin
         format_code = riff_code;
      end else if (code32 != fmc_pkg::FMT_UNKNOWN) begin
         format_code = code32;
      end else if (code24 != fmc_pkg::FMT_UNKNOWN) begin
         format_code = code24;
      end else if (code16 != fmc_pkg::FMT_UNKNOWN) begin
         format_code = code16;
      end else if ((sig[63:48] & fmc_pkg::ADTS_MASK) == fmc_pkg::ADTS_SYNC) begin
         format_code = fmc_pkg::FMT_ADTS;
      end else if (sig[63:53] == fmc_pkg::MPA_SYNC) begin
         format_code = fmc_pkg::FMT_MPA;
      end else begin
         format_code = fmc_pkg::FMT_UNKNOWN;
      end
   end

endmodule

FILE: rtl/file_magic_classifier.sv
// ----------------------------------------------------------------------------
// file_magic_classifier
// Container-format detection from the first sixteen bytes of a file.
// ----------------------------------------------------------------------------
// One request per cycle while the output is not stalled: a header is
// registered at the input, the compare bank and priority select run in the
// following cycle, and the code lands in the output register. The compare
// bank between those two registers is a single combinational stage. A stalled
// output holds both stages; the input keeps taking requests as long as the
// output side moves or a stage is empty.
module file_magic_classifier (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [63:0] head_word, [127:64] tail_word, [132:128] byte_count, rest zero
   input  logic [fmc_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [5:0] format_code, rest zero
   output logic [fmc_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   logic               in_valid_ff;
   logic               in_valid_in;
   fmc_pkg::word_type  head_ff;
   fmc_pkg::word_type  tail_ff;
   fmc_pkg::count_type count_ff;
   logic               out_valid_ff;
   logic               out_valid_in;
   fmc_pkg::code_type  code_ff;
   fmc_pkg::code_type  code_calc;
   logic               out_free;
   logic               req_take;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || out_free;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_free) begin
         out_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         head_ff  <= req_tdata[63:0];
         tail_ff  <= req_tdata[127:64];
         count_ff <= req_tdata[132:128];
      end
      if (out_free && in_valid_ff) begin
         code_ff <= code_calc;
      end
   end

   fmc_classify u_classify (
      .head_word   (head_ff),
      .tail_word   (tail_ff),
      .byte_count  (count_ff),
      .format_code (code_calc)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(fmc_pkg::RSP_DATA_W - fmc_pkg::CODE_W){1'b0}}, code_ff};

   // A taken request always occupies the input stage next cycle
   a_take_loads: assert property (@(posedge clock) disable iff (reset)
      req_take |=> in_valid_ff)
      else $error("request taken but input stage empty");

   // A held header must not be dropped while the output stalls
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_valid_ff && !rsp_tready) |=> (in_valid_ff && $stable(head_ff)))
      else $error("input stage lost a header during stall");

   // Short headers give unknown
   a_short_unknown: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_free && (count_ff < fmc_pkg::CNT_MIN))
      |=> (rsp_tdata[5:0] == fmc_pkg::FMT_UNKNOWN))
      else $error("short header not classed unknown");

   // Codes stay within the defined range
   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (code_ff <= fmc_pkg::FMT_LAST))
      else $error("format code out of range");

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stream-level test of the file magic classifier. Headers go in on the req_
// channel, each is classified by a local copy of the priority checks, and the
// codes coming back on rsp_ are compared in order. Directed headers cover the
// short-count and RIFF/YUV corner cases; random headers mostly carry a real
// signature with random surroundings, under several idle/stall mixes and one
// long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int STALL_LIMIT = 5000;
   localparam int HOLD_CYCLES = 300;
   localparam int GAP_MAX     = 40;
   localparam int NUM_MAGICS  = 49;

   // Holds the codes still owed by the block, oldest first
   class format_scoreboard;
      fmc_pkg::code_type pending_codes[$];
      int                errors = 0;

      function fmc_pkg::code_type classify_header(fmc_pkg::word_type head,
                                                  fmc_pkg::word_type tail,
                                                  fmc_pkg::count_type count);
         fmc_pkg::word_type  sig;
         fmc_pkg::count_type n;
         n = (count > fmc_pkg::CNT_FULL) ? fmc_pkg::CNT_FULL : count;
         if (n >= fmc_pkg::CNT_WORD8)
            sig = head;
         else if (n >= fmc_pkg::CNT_WORD4)
            sig = {head[63:32], 32'h0};
         else if (n >= fmc_pkg::CNT_MIN)
            sig = {head[63:48], 48'h0};
         else
            return fmc_pkg::FMT_UNKNOWN;

         case (sig)
            fmc_pkg::SIG_APETAG: return fmc_pkg::FMT_APETAG;
            fmc_pkg::SIG_AR:     return fmc_pkg::FMT_AR;
            fmc_pkg::SIG_ASF_A:  return fmc_pkg::FMT_ASF;
            fmc_pkg::SIG_ASF_B:  return fmc_pkg::FMT_ASF;
            fmc_pkg::SIG_PNG:    return fmc_pkg::FMT_PNG;
            default: ;
         endcase
         if (sig == fmc_pkg::SIG_YUV4MPEG && n >= fmc_pkg::CNT_YUV &&
             tail[63:56] == fmc_pkg::YUV_BYTE8 && tail[55:48] == fmc_pkg::YUV_BYTE9)
            return fmc_pkg::FMT_YUV4MPEG;
         // box tag sits at bytes 4..7
         if (sig[31:0] == fmc_pkg::SIG_MP4)
            return fmc_pkg::FMT_MP4;
         if (sig[31:0] == fmc_pkg::SIG_MOOV)
            return fmc_pkg::FMT_QT;
         if (sig[63:8] == fmc_pkg::SIG_RAR)
            return fmc_pkg::FMT_RAR;
         case (sig[63:16])
            48'h474946383761: return fmc_pkg::FMT_GIF87A;
            48'h474946383961: return fmc_pkg::FMT_GIF89A;
            48'h377ABCAF271C: return fmc_pkg::FMT_7Z;
            48'hFD377A585A00: return fmc_pkg::FMT_XZ;
            default: ;
         endcase
         if (sig[63:24] == fmc_pkg::SIG_AIFF)
            return fmc_pkg::FMT_AIFF;
         if (sig[63:32] == fmc_pkg::SIG_RIFF) begin
            if (n >= fmc_pkg::CNT_FULL && tail == fmc_pkg::SIG_RIFF_AVI)
               return fmc_pkg::FMT_AVI;
            if (n >= fmc_pkg::CNT_WAVE && tail[63:32] == fmc_pkg::SIG_WAVE)
               return fmc_pkg::FMT_WAVE;
            return fmc_pkg::FMT_RIFF;
         end
         case (sig[63:32])
            32'h42424344: return fmc_pkg::FMT_DIRAC;
            32'h7F454C46: return fmc_pkg::FMT_ELF;
            32'h664C6143: return fmc_pkg::FMT_FLAC;
            32'h444B4946: return fmc_pkg::FMT_IVF;
            32'hCAFEBABE: return fmc_pkg::FMT_JAVA;
            32'h1A45DFA3: return fmc_pkg::FMT_EBML;
            32'h4D546864: return fmc_pkg::FMT_MIDI;
            32'h4D414320: return fmc_pkg::FMT_MONKEY;
            32'h4F676753: return fmc_pkg::FMT_OGG;
            32'h38425053: return fmc_pkg::FMT_PSD;
            32'h4D4D002A: return fmc_pkg::FMT_TIFF_BE;
            32'h49492A00: return fmc_pkg::FMT_TIFF_LE;
            32'hFFFE0000: return fmc_pkg::FMT_UTF32;
            32'h7776706B: return fmc_pkg::FMT_WAVPACK;
            32'h00000100: return fmc_pkg::FMT_ICO;
            32'h4C5A4950: return fmc_pkg::FMT_LZIP;
            32'h504B0304: return fmc_pkg::FMT_ZIP;
            32'h504B0506: return fmc_pkg::FMT_ZIP;
            32'h504B0708: return fmc_pkg::FMT_ZIP;
            32'h28B52FFD: return fmc_pkg::FMT_ZSTD;
            default: ;
         endcase
         case (sig[63:40])
            24'h425A68: return fmc_pkg::FMT_BZIP2;
            24'h464C56: return fmc_pkg::FMT_FLV;
            24'h1F8B08: return fmc_pkg::FMT_GZIP;
            24'h494433: return fmc_pkg::FMT_ID3V2;
            24'hEFBBBF: return fmc_pkg::FMT_UTF8;
            default: ;
         endcase
         case (sig[63:48])
            16'h0B77: return fmc_pkg::FMT_AC3;
            16'hFFD8: return fmc_pkg::FMT_JPEG;
            16'h1FA0: return fmc_pkg::FMT_LHA;
            16'h1F9D: return fmc_pkg::FMT_LZW;
            16'h4D5A: return fmc_pkg::FMT_PE;
            16'hFFFE: return fmc_pkg::FMT_UTF16;
            16'h424D: return fmc_pkg::FMT_BMP;
            default: ;
         endcase
         if ((sig[63:48] & fmc_pkg::ADTS_MASK) == fmc_pkg::ADTS_SYNC)
            return fmc_pkg::FMT_ADTS;
         if (sig[63:53] == fmc_pkg::MPA_SYNC)
            return fmc_pkg::FMT_MPA;
         return fmc_pkg::FMT_UNKNOWN;
      endfunction

      function void note_request(fmc_pkg::word_type head, fmc_pkg::word_type tail,
                                 fmc_pkg::count_type count);
         pending_codes.push_back(classify_header(head, tail, count));
      endfunction

      function void check_response(fmc_pkg::code_type code);
         fmc_pkg::code_type want;
         if (pending_codes.size() == 0) begin
            $display("%0t: response with nothing outstanding, got code %0d", $time, code);
            errors++;
            return;
         end
         want = pending_codes.pop_front();
         if (code !== want) begin
            $display("%0t: format_code mismatch, expected %0d, got %0d", $time, want, code);
            errors++;
         end
      endfunction
   endclass

   logic                           clock      = 1'b0;
   logic                           reset      = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [fmc_pkg::REQ_DATA_W-1:0] req_tdata  = '0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [fmc_pkg::RSP_DATA_W-1:0] rsp_tdata;

   format_scoreboard sb = new();

   int   send_idle_pct  = 0;
   int   recv_stall_pct = 0;
   logic hold_go        = 1'b0;
   logic rx_hold        = 1'b0;
   int   quiet_cycles   = 0;

   file_magic_classifier dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #2 clock = ~clock;

   // Result side: random back-pressure, plus the long hold-off when asked
   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready && !reset)
         sb.check_response(rsp_tdata[fmc_pkg::CODE_W-1:0]);
      if (reset)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= !rx_hold && ($urandom_range(0, 99) >= recv_stall_pct);
   end

   initial begin
      wait (hold_go);
      @(posedge clock);
      rx_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rx_hold <= 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Signature templates: pattern bits and the mask of bits that matter
   function automatic void magic_pattern(int sel, output fmc_pkg::word_type pat,
                                         output fmc_pkg::word_type mask);
      logic [67:0] e;
      int          nbytes;
      e = '0;
      case (sel)
         0: begin
            pat = {32'h0, fmc_pkg::SIG_MP4};  mask = 64'hFFFF_FFFF; return;
         end
         1: begin
            pat = {32'h0, fmc_pkg::SIG_MOOV}; mask = 64'hFFFF_FFFF; return;
         end
         2: begin
            pat = {fmc_pkg::ADTS_SYNC, 48'h0}; mask = {fmc_pkg::ADTS_MASK, 48'h0}; return;
         end
         3: begin
            pat = {fmc_pkg::MPA_SYNC, 53'h0};  mask = {11'h7FF, 53'h0};   return;
         end
         4:  e = {4'd8, fmc_pkg::SIG_APETAG};
         5:  e = {4'd8, fmc_pkg::SIG_AR};
         6:  e = {4'd8, fmc_pkg::SIG_ASF_A};
         7:  e = {4'd8, fmc_pkg::SIG_ASF_B};
         8:  e = {4'd8, fmc_pkg::SIG_PNG};
         9:  e = {4'd8, fmc_pkg::SIG_YUV4MPEG};
         10: e = {4'd7, 8'h0, fmc_pkg::SIG_RAR};
         11: e = {4'd6, 64'h474946383761};
         12: e = {4'd6, 64'h474946383961};
         13: e = {4'd6, 64'h377ABCAF271C};
         14: e = {4'd6, 64'hFD377A585A00};
         15: e = {4'd5, 24'h0, fmc_pkg::SIG_AIFF};
         16: e = {4'd4, 32'h0, fmc_pkg::SIG_RIFF};
         17: e = {4'd4, 64'h42424344};
         18: e = {4'd4, 64'h7F454C46};
         19: e = {4'd4, 64'h664C6143};
         20: e = {4'd4, 64'h444B4946};
         21: e = {4'd4, 64'hCAFEBABE};
         22: e = {4'd4, 64'h1A45DFA3};
         23: e = {4'd4, 64'h4D546864};
         24: e = {4'd4, 64'h4D414320};
         25: e = {4'd4, 64'h4F676753};
         26: e = {4'd4, 64'h38425053};
         27: e = {4'd4, 64'h4D4D002A};
         28: e = {4'd4, 64'h49492A00};
         29: e = {4'd4, 64'hFFFE0000};
         30: e = {4'd4, 64'h7776706B};
         31: e = {4'd4, 64'h00000100};
         32: e = {4'd4, 64'h4C5A4950};
         33: e = {4'd4, 64'h504B0304};
         34: e = {4'd4, 64'h504B0506};
         35: e = {4'd4, 64'h504B0708};
         36: e = {4'd4, 64'h28B52FFD};
         37: e = {4'd3, 64'h425A68};
         38: e = {4'd3, 64'h464C56};
         39: e = {4'd3, 64'h1F8B08};
         40: e = {4'd3, 64'h494433};
         41: e = {4'd3, 64'hEFBBBF};
         42: e = {4'd2, 64'h0B77};
         43: e = {4'd2, 64'hFFD8};
         44: e = {4'd2, 64'h1FA0};
         45: e = {4'd2, 64'h1F9D};
         46: e = {4'd2, 64'h4D5A};
         47: e = {4'd2, 64'hFFFE};
         default: e = {4'd2, 64'h424D};
      endcase
      nbytes = int'(e[67:64]);
      pat  = e[63:0] << (64 - 8 * nbytes);
      mask = ~64'h0 << (64 - 8 * nbytes);
   endfunction

   task automatic send_header(fmc_pkg::word_type head, fmc_pkg::word_type tail,
                              fmc_pkg::count_type count);
      int gap;
      gap = 0;
      while (gap < GAP_MAX && $urandom_range(0, 99) < send_idle_pct)
         gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b000, count, tail, head};
      do @(posedge clock); while (!req_tready);
      sb.note_request(head, tail, count);
   endtask

   task automatic send_random_headers(int num);
      fmc_pkg::word_type  head, tail, pat, mask;
      fmc_pkg::count_type count;
      int                 r;
      repeat (num) begin
         head = {$urandom, $urandom};
         tail = {$urandom, $urandom};
         if ($urandom_range(0, 99) < 80) begin
            magic_pattern($urandom_range(0, NUM_MAGICS - 1), pat, mask);
            head = (head & ~mask) | (pat & mask);
            case ($urandom_range(0, 3))
               0: tail[63:48] = {fmc_pkg::YUV_BYTE8, fmc_pkg::YUV_BYTE9};
               1: tail = fmc_pkg::SIG_RIFF_AVI;
               2: tail[63:32] = fmc_pkg::SIG_WAVE;
               default: ;
            endcase
            // near misses: a bit flipped anywhere in the head and, independently, the tail
            if ($urandom_range(0, 9) == 0)
               head[$urandom_range(0, 63)] ^= 1'b1;
            if ($urandom_range(0, 9) == 0)
               tail[$urandom_range(0, 63)] ^= 1'b1;
         end
         r = $urandom_range(0, 19);
         if (r < 10)
            count = fmc_pkg::CNT_FULL;
         else if (r < 18)
            count = fmc_pkg::count_type'($urandom_range(0, 15));
         else
            count = fmc_pkg::count_type'($urandom_range(17, 31));
         send_header(head, tail, count);
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // corner cases, no idling
      send_header(64'h0, 64'h0, 5'd0);
      send_header(~64'h0, ~64'h0, fmc_pkg::CNT_FULL);
      send_header(~64'h0, ~64'h0, 5'd31);
      send_header(fmc_pkg::SIG_APETAG, 64'h0, 5'd1);
      send_header(64'h1F8B_0800_1234_5678, 64'h0, fmc_pkg::CNT_MIN);
      send_header(64'h1FA0_55AA_55AA_55AA, 64'h0, 5'd3);
      send_header(64'h504B_0304_DEAD_BEEF, 64'h0, 5'd5);
      send_header(64'h7F45_4C46_FFFF_FFFF, 64'h0, 5'd7);
      send_header(fmc_pkg::SIG_APETAG, ~64'h0, fmc_pkg::CNT_WORD8);
      send_header(fmc_pkg::SIG_PNG, 64'h0, fmc_pkg::CNT_FULL);
      send_header(fmc_pkg::SIG_YUV4MPEG, 64'h3220_0000_0000_0000, fmc_pkg::CNT_YUV);
      send_header(fmc_pkg::SIG_YUV4MPEG, 64'h3220_0000_0000_0000, 5'd9);
      send_header(fmc_pkg::SIG_YUV4MPEG, 64'h3221_0000_0000_0000, fmc_pkg::CNT_FULL);
      send_header({32'h0000_0018, fmc_pkg::SIG_MP4}, 64'h0, fmc_pkg::CNT_WORD8);
      send_header({32'h0000_0018, fmc_pkg::SIG_MP4}, 64'h0, 5'd7);
      send_header({32'h0000_0100, fmc_pkg::SIG_MOOV}, 64'h0, fmc_pkg::CNT_FULL);
      send_header({fmc_pkg::SIG_RAR, 8'hA5}, 64'h0, fmc_pkg::CNT_WAVE);
      send_header(64'h4749_4638_3961_0102, 64'h0, fmc_pkg::CNT_FULL);
      send_header({fmc_pkg::SIG_AIFF, 24'h0A_0B0C}, 64'h0, fmc_pkg::CNT_FULL);
      send_header({fmc_pkg::SIG_RIFF, 32'h1234_5678}, fmc_pkg::SIG_RIFF_AVI,
                  fmc_pkg::CNT_FULL);
      send_header({fmc_pkg::SIG_RIFF, 32'h1234_5678}, fmc_pkg::SIG_RIFF_AVI, 5'd15);
      send_header({fmc_pkg::SIG_RIFF, 32'h1234_5678}, {fmc_pkg::SIG_WAVE, 32'h0},
                  fmc_pkg::CNT_WAVE);
      send_header({fmc_pkg::SIG_RIFF, 32'h1234_5678}, {fmc_pkg::SIG_WAVE, 32'h0}, 5'd11);
      send_header({fmc_pkg::SIG_RIFF, 32'h0}, 64'h0, fmc_pkg::CNT_WORD4);
      send_header({fmc_pkg::ADTS_SYNC | 16'h0009, 48'h0}, 64'h0, fmc_pkg::CNT_MIN);
      send_header(64'hFFE3_0000_0000_0000, 64'h0, fmc_pkg::CNT_FULL);
      send_header(fmc_pkg::SIG_ASF_B, 64'h0, fmc_pkg::CNT_FULL);

      send_random_headers(400);

      send_idle_pct = 84;
      send_random_headers(330);

      send_idle_pct  = 0;
      recv_stall_pct = 84;
      send_random_headers(330);

      send_idle_pct  = 18;
      recv_stall_pct = 18;
      send_random_headers(320);

      // long output hold-off while requests keep coming
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_go = 1'b1;
      send_random_headers(40);

      req_tvalid <= 1'b0;
      while (sb.pending_codes.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);

      if (sb.errors == 0 && sb.pending_codes.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/fmc_pkg.sv
rtl/fmc_classify.sv
rtl/file_magic_classifier.sv
tb/tb_top.sv
